>>> src/encoder_harmonic_correction_defines.svh
// Assertion macros for the encoder harmonic correction block.
`ifndef ENCODER_HARMONIC_CORRECTION_DEFINES_SVH
`define ENCODER_HARMONIC_CORRECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EHC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define EHC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define EHC_ASSERT_IMPL(lbl, ante, cons)
`define EHC_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> src/ehc_pkg.sv
// Shared constants and quarter-wave sine table for the harmonic correction cells.
package ehc_pkg;

  localparam int COEFF_W     = 32;
  localparam int AMP_W       = 16;
  localparam int PHASE_W     = 16;
  localparam int TABLE_STEPS = 64;
  localparam int STEP_BITS   = 6;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_SHIFT   = 14 - STEP_BITS;
  localparam int IDX_W       = STEP_BITS + 1;
  localparam int SINE_W      = 15;

  localparam logic [14:0] QUARTER = 15'h4000;

  localparam logic [SINE_W-1:0] SINE_TAB [0:TABLE_STEPS] = '{
    15'd0,     15'd804,   15'd1608,  15'd2411,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
    15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
    15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
    15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
    15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
    15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
    15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
    15'd32767
  };

endpackage

>>> src/encoder_harmonic_correction.sv
// Encoder harmonic correction: takes one raw angle per cycle unless in_stall is high and
// returns it with the harmonic error sum removed. Each harmonic is one cell of three
// register stages (table lookup, interpolation, amplitude multiply); one transfer per
// cycle is sustained while out_stall is low.
// Stages with no item fill while the output is stalled.
`include "encoder_harmonic_correction_defines.svh"

module encoder_harmonic_correction #(
  parameter int HARMONIC_COUNT = 5,
  parameter int ANGLE_BITS     = 21
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [$clog2(HARMONIC_COUNT+1)-1:0]  cfg_index,
  input  logic [ehc_pkg::COEFF_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ANGLE_BITS-1:0]                in_raw_angle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ANGLE_BITS-1:0]                out_corrected_angle
);
  import ehc_pkg::*;

  localparam int CFG_IDX_W = $clog2(HARMONIC_COUNT + 1);

  logic [COEFF_W-1:0]    coeff_r [HARMONIC_COUNT];

  logic                  ch_valid [HARMONIC_COUNT+1];
  logic                  ch_ready [HARMONIC_COUNT+1];
  logic [ANGLE_BITS-1:0] ch_raw   [HARMONIC_COUNT+1];
  logic [ANGLE_BITS-1:0] ch_arg   [HARMONIC_COUNT+1];
  logic [ANGLE_BITS-1:0] ch_acc   [HARMONIC_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HARMONIC_COUNT; k++) begin
        coeff_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < HARMONIC_COUNT; k++) begin
        if (cfg_wr_en && (cfg_index == CFG_IDX_W'(k))) begin
          coeff_r[k] <= cfg_data;
        end
      end
    end
  end

  assign ch_valid[0] = in_valid;
  assign ch_raw[0]   = in_raw_angle;
  assign ch_arg[0]   = '0;
  assign ch_acc[0]   = in_raw_angle;
  assign in_stall    = !ch_ready[0];

  for (genvar g = 0; g < HARMONIC_COUNT; g++) begin : g_cell
    ehc_cell #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .coeff    (coeff_r[g]),
      .up_valid (ch_valid[g]),
      .up_ready (ch_ready[g]),
      .up_raw   (ch_raw[g]),
      .up_arg   (ch_arg[g]),
      .up_acc   (ch_acc[g]),
      .dn_valid (ch_valid[g+1]),
      .dn_ready (ch_ready[g+1]),
      .dn_raw   (ch_raw[g+1]),
      .dn_arg   (ch_arg[g+1]),
      .dn_acc   (ch_acc[g+1])
    );
  end

  assign ch_ready[HARMONIC_COUNT] = !out_stall;
  assign out_valid                = ch_valid[HARMONIC_COUNT];
  assign out_corrected_angle      = ch_acc[HARMONIC_COUNT];

  `EHC_ASSERT_IMPL(a_stall_needs_full_out, in_stall, out_valid && out_stall)
  `EHC_ASSERT_IMPL(a_free_out_never_blocks, !out_stall, !in_stall)
  `EHC_ASSERT_NEVER(a_stall_without_result, in_stall && !out_valid)

endmodule

>>> src/ehc_cell.sv
// One harmonic cell: phase angle, interpolated sine, scaled term subtracted from the angle.
module ehc_cell #(
  parameter int ANGLE_BITS = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ehc_pkg::COEFF_W-1:0] coeff,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [ANGLE_BITS-1:0]       up_raw,
  input  logic [ANGLE_BITS-1:0]       up_arg,
  input  logic [ANGLE_BITS-1:0]       up_acc,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [ANGLE_BITS-1:0]       dn_raw,
  output logic [ANGLE_BITS-1:0]       dn_arg,
  output logic [ANGLE_BITS-1:0]       dn_acc
);
  import ehc_pkg::*;

  logic                  v1_r, v2_r, v3_r;
  logic                  s1_ready, s2_ready, s3_ready;

  logic [ANGLE_BITS-1:0] raw1_r, arg1_r, acc1_r;
  logic [ANGLE_BITS-1:0] raw2_r, arg2_r, acc2_r;
  logic [ANGLE_BITS-1:0] raw3_r, arg3_r, acc3_r;

  logic [ANGLE_BITS-1:0] arg_nxt;
  logic [PHASE_W-1:0]    pang;
  logic [1:0]            quad;
  logic [14:0]           fold;
  logic [IDX_W-1:0]      idx, idx_hi;
  logic [FRAC_BITS-1:0]  frac_nxt, frac1_r;
  logic [SINE_W-1:0]     a0_nxt, a1, a0_1_r;
  logic signed [16:0]    step_nxt, step1_r;
  logic                  neg1_r;

  logic signed [25:0]    interp;
  logic signed [17:0]    mag;
  logic signed [17:0]    sine_nxt;
  logic signed [16:0]    sine2_r;

  logic signed [AMP_W-1:0]   amp;
  logic signed [32:0]        prod;
  logic signed [17:0]        term;
  logic [ANGLE_BITS-1:0]     acc_nxt;

  assign s3_ready = !v3_r || dn_ready;
  assign s2_ready = !v2_r || s3_ready;
  assign s1_ready = !v1_r || s2_ready;
  assign up_ready = s1_ready;

  always_comb begin
    arg_nxt  = up_arg + up_raw;
    pang     = arg_nxt[ANGLE_BITS-1 -: PHASE_W] + coeff[PHASE_W-1:0];
    quad     = pang[15:14];
    fold     = quad[0] ? (QUARTER - {1'b0, pang[13:0]}) : {1'b0, pang[13:0]};
    idx      = fold[14:IDX_SHIFT];
    frac_nxt = fold[IDX_SHIFT-1 -: FRAC_BITS];
    idx_hi   = (idx == IDX_W'(TABLE_STEPS)) ? idx : idx + IDX_W'(1);
    a0_nxt   = SINE_TAB[idx];
    a1       = SINE_TAB[idx_hi];
    step_nxt = $signed({2'b00, a1}) - $signed({2'b00, a0_nxt});
  end

  always_comb begin
    interp   = step1_r * $signed({1'b0, frac1_r});
    mag      = $signed({3'b000, a0_1_r}) + interp[25:8];
    sine_nxt = neg1_r ? -mag : mag;
  end

  always_comb begin
    amp     = $signed(coeff[COEFF_W-1 -: AMP_W]);
    prod    = amp * sine2_r;
    term    = prod[32:15];
    acc_nxt = acc2_r - ANGLE_BITS'(term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_r <= up_valid;
      end
      if (s2_ready) begin
        v2_r <= v1_r;
      end
      if (s3_ready) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      raw1_r  <= up_raw;
      arg1_r  <= arg_nxt;
      acc1_r  <= up_acc;
      a0_1_r  <= a0_nxt;
      step1_r <= step_nxt;
      frac1_r <= frac_nxt;
      neg1_r  <= quad[1];
    end
    if (s2_ready && v1_r) begin
      raw2_r  <= raw1_r;
      arg2_r  <= arg1_r;
      acc2_r  <= acc1_r;
      sine2_r <= sine_nxt[16:0];
    end
    if (s3_ready && v2_r) begin
      raw3_r <= raw2_r;
      arg3_r <= arg2_r;
      acc3_r <= acc_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_raw   = raw3_r;
  assign dn_arg   = arg3_r;
  assign dn_acc   = acc3_r;

endmodule
